@@ rtl/rps_pkg.sv @@
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, constants and helper functions of the reflow profile sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

    localparam int TEMP_BITS = 9;              // temperature / setpoint width
    localparam int SP_W      = TEMP_BITS + 1;  // setpoint plus ramp carry
    localparam int PADDR_W   = 5;              // five registers at 4*i
    localparam int IDX_W     = PADDR_W - 2;
    localparam int PCT_W     = 11;
    localparam int CNT_W     = 16;             // second counter
    localparam int IDLE_W    = 8;              // idle-display counter
    localparam int NUM_W     = 20;             // percent numerator magnitude
    localparam int SNUM_W    = NUM_W + 1;      // signed numerator
    localparam int SPAN_W    = 10;             // signed phase span
    localparam int DVS_W     = 7;              // divisor, at most 102
    localparam int ACC_W     = NUM_W + 2;      // quotient plus offset, signed
    localparam int DIV_STEPS = NUM_W;          // one quotient bit per cycle
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [TEMP_BITS-1:0] AMBIENT_TEMP   = TEMP_BITS'(38);
    localparam logic [TEMP_BITS-1:0] PEAK_EXIT_TEMP = TEMP_BITS'(215);
    localparam logic [SPAN_W-1:0]    PEAK_SPAN_TOP  = SPAN_W'(217);
    localparam logic [SPAN_W-1:0]    AMBIENT_SPAN   = SPAN_W'(38);
    localparam logic [CNT_W-1:0]     MINUTE_SECONDS = CNT_W'(60);
    localparam logic [SP_W-1:0]      RAMP_STEP      = SP_W'(3);
    localparam logic [7:0]           HOLD_DROP_LEAD = 8'd10;
    localparam logic [7:0]           RECIP_5        = 8'd205; // 205/1024 ~ 1/5
    localparam int                   RECIP_SHIFT    = 10;

    localparam logic signed [7:0] PCT_OFS_PREHEAT = 8'sd0;
    localparam logic signed [7:0] PCT_OFS_SOAK    = 8'sd25;
    localparam logic signed [7:0] PCT_OFS_PEAK    = 8'sd50;
    localparam logic signed [7:0] PCT_OFS_HOLD    = 8'sd75;
    localparam logic signed [PCT_W-1:0] PCT_DONE  = PCT_W'(100);
    localparam logic signed [ACC_W-1:0] PCT_MIN   = -(ACC_W'(1024));
    localparam logic signed [ACC_W-1:0] PCT_MAX   = ACC_W'(1023);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PREHEAT = 3'd1,
        PH_SOAK    = 3'd2,
        PH_PEAK    = 3'd3,
        PH_HOLD    = 3'd4
    } phase_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PREHEAT_TEMP  = 3'd0,
        REG_SOAK_SECONDS  = 3'd1,
        REG_PEAK_TEMP     = 3'd2,
        REG_HOLD_SECONDS  = 3'd3,
        REG_DISPLAY_SLEEP = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] preheat_temp;
        logic [7:0] soak_seconds;
        logic [8:0] peak_temp;
        logic [7:0] hold_seconds;
        logic [7:0] display_sleep_seconds;
    } cfg_t;

    // span*10/25 == floor(2*span/5) for 0 <= span < 256; result forced to >= 1
    function automatic logic [DVS_W-1:0] divisor_of(input logic signed [SPAN_W-1:0] span);
        logic [8:0]         twice;
        logic [16:0]        prod;
        logic [DVS_W-1:0]   d;
        twice = {span[7:0], 1'b0};
        prod  = 17'(twice) * 17'(RECIP_5);
        d     = prod[16:RECIP_SHIFT];
        if (span <= 0 || d == '0)
        begin
            d = DVS_W'(1);
        end
        return d;
    endfunction

    function automatic logic signed [PCT_W-1:0] sat_pct(input logic signed [ACC_W-1:0] v);
        logic signed [PCT_W-1:0] r;
        if (v < PCT_MIN)
        begin
            r = PCT_MIN[PCT_W-1:0];
        end
        else if (v > PCT_MAX)
        begin
            r = PCT_MAX[PCT_W-1:0];
        end
        else
        begin
            r = v[PCT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/reflow_profile_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// reflow_profile_sequencer_unit
// Reflow profile sequencer: preheat ramp, soak, peak ramp and hold on
// one-second tick beats, with progress percent, minute pulse and display wake.
//
//   channel   signals                                   direction
//   --------  ----------------------------------------  ---------
//   in        in_valid/in_ready, action .. start_setpoint   sink
//   out       out_valid/out_ready, phase .. display_toggle  source
//   cfg       psel/penable/pwrite/paddr/pwdata/prdata       APB slave
//
// A beat whose phase needs a progress percent runs from accept through the
// bit-serial divider, one quotient bit per cycle, to the done state; start
// beats, idle ticks and the hold end skip it. Beats are taken only in idle.
// Reset (rst_n, async) returns to idle with all counters cleared.
// A held-off result sits in the output register; the next beat is still
// taken and waits in the done state until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module reflow_profile_sequencer_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [rps_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    // input beats
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                action,
    input  wire logic [rps_pkg::TEMP_BITS-1:0]       meas_temp,
    input  wire logic                                heater_on,
    input  wire logic                                temp_reached,
    input  wire logic                                display_asleep,
    input  wire logic [rps_pkg::TEMP_BITS-1:0]       start_setpoint,
    // result beats
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [2:0]                          phase,
    output logic signed [rps_pkg::PCT_W-1:0]         percent,
    output logic      [rps_pkg::TEMP_BITS-1:0]       setpoint,
    output logic                                     heater_stop,
    output logic                                     minute_pulse,
    output logic                                     display_toggle_request
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DIV  = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    rps_pkg::cfg_t cfg;

    state_t                              st_reg,       st_next;
    rps_pkg::phase_t                     phase_reg,    phase_next;
    logic [rps_pkg::TEMP_BITS-1:0]       setpoint_reg, setpoint_next;
    logic [rps_pkg::CNT_W-1:0]           sec_cnt_reg,  sec_cnt_next;
    logic [rps_pkg::IDLE_W-1:0]          idle_cnt_reg, idle_cnt_next;
    logic signed [rps_pkg::PCT_W-1:0]    percent_reg,  percent_next;
    logic                                stop_reg,     stop_next;
    logic                                minute_reg,   minute_next;
    logic                                toggle_reg,   toggle_next;
    logic                                neg_reg,      neg_next;
    logic signed [7:0]                   ofs_reg,      ofs_next;
    logic                                out_valid_reg, out_valid_next;
    rps_pkg::phase_t                     out_phase_reg, out_phase_next;
    logic signed [rps_pkg::PCT_W-1:0]    out_pct_reg,   out_pct_next;
    logic [rps_pkg::TEMP_BITS-1:0]       out_sp_reg,    out_sp_next;
    logic                                out_stop_reg,  out_stop_next;
    logic                                out_min_reg,   out_min_next;
    logic                                out_tog_reg,   out_tog_next;

    // tick arithmetic
    logic                                idle_tick;
    logic [rps_pkg::IDLE_W-1:0]          idle_inc;
    logic [rps_pkg::CNT_W-1:0]           sec_inc;
    logic                                minute_hit;
    logic [rps_pkg::CNT_W-1:0]           sec_tick;
    logic signed [rps_pkg::SNUM_W-1:0]   now_ext;
    logic signed [rps_pkg::SNUM_W-1:0]   pre_ext;
    logic signed [rps_pkg::SNUM_W-1:0]   cnt_ext;
    logic signed [rps_pkg::SNUM_W-1:0]   diff;
    logic signed [rps_pkg::SNUM_W-1:0]   num;
    logic [rps_pkg::NUM_W-1:0]           num_mag;
    logic signed [rps_pkg::SPAN_W-1:0]   span;
    logic [rps_pkg::SPAN_W-1:0]          pre_span;
    logic [rps_pkg::SP_W-1:0]            sp_ramp;
    logic [rps_pkg::SP_W-1:0]            pre_sp;
    logic                                hold_drop;
    logic                                hold_end;

    // divider
    logic                                div_start;
    logic                                div_done;
    logic [rps_pkg::NUM_W-1:0]           div_q;
    logic [rps_pkg::DVS_W-1:0]           div_dvs;
    logic signed [rps_pkg::ACC_W-1:0]    q_signed;
    logic signed [rps_pkg::ACC_W-1:0]    pct_acc;

    rps_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rps_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready               = (st_reg == ST_IDLE);
    assign out_valid              = out_valid_reg;
    assign phase                  = out_phase_reg;
    assign percent                = out_pct_reg;
    assign setpoint               = out_sp_reg;
    assign heater_stop            = out_stop_reg;
    assign minute_pulse           = out_min_reg;
    assign display_toggle_request = out_tog_reg;

    // counters, as seen by the phase step
    assign idle_tick  = (meas_temp == rps_pkg::AMBIENT_TEMP) && !heater_on;
    assign idle_inc   = idle_cnt_reg + 1'b1;
    assign sec_inc    = sec_cnt_reg + 1'b1;
    assign minute_hit = temp_reached && (sec_inc == rps_pkg::MINUTE_SECONDS);
    assign sec_tick   = minute_hit ? '0 : sec_inc;

    assign now_ext  = rps_pkg::SNUM_W'(meas_temp);
    assign pre_ext  = rps_pkg::SNUM_W'(cfg.preheat_temp);
    assign cnt_ext  = rps_pkg::SNUM_W'(sec_tick);
    assign pre_span = rps_pkg::SPAN_W'(cfg.preheat_temp);

    // per-phase numerator difference, span and offset
    always_comb
    begin
        case (phase_reg)
            rps_pkg::PH_PREHEAT:
            begin
                diff     = now_ext - rps_pkg::SNUM_W'(rps_pkg::AMBIENT_TEMP);
                span     = pre_span - rps_pkg::AMBIENT_SPAN;
                ofs_next = rps_pkg::PCT_OFS_PREHEAT;
            end
            rps_pkg::PH_SOAK:
            begin
                diff     = cnt_ext;
                span     = rps_pkg::SPAN_W'(cfg.soak_seconds);
                ofs_next = rps_pkg::PCT_OFS_SOAK;
            end
            rps_pkg::PH_PEAK:
            begin
                diff     = now_ext - pre_ext;
                span     = rps_pkg::PEAK_SPAN_TOP - pre_span;
                ofs_next = rps_pkg::PCT_OFS_PEAK;
            end
            rps_pkg::PH_HOLD:
            begin
                diff     = cnt_ext;
                span     = rps_pkg::SPAN_W'(cfg.hold_seconds);
                ofs_next = rps_pkg::PCT_OFS_HOLD;
            end
            default:
            begin
                diff     = '0;
                span     = '0;
                ofs_next = ofs_reg;
            end
        endcase
    end

    // x*10 as two shifts and an add
    assign num      = (diff <<< 3) + (diff <<< 1);
    assign neg_next = num[rps_pkg::SNUM_W-1];
    assign num_mag  = neg_next ? rps_pkg::NUM_W'(-num) : num[rps_pkg::NUM_W-1:0];
    assign div_dvs  = rps_pkg::divisor_of(span);

    assign sp_ramp   = {1'b0, setpoint_reg} + rps_pkg::RAMP_STEP;
    assign pre_sp    = rps_pkg::SP_W'(cfg.preheat_temp);
    // drop ten seconds before the end; never when the hold is too short
    assign hold_drop = (cfg.hold_seconds >= rps_pkg::HOLD_DROP_LEAD)
                    && (sec_tick == rps_pkg::CNT_W'(cfg.hold_seconds - rps_pkg::HOLD_DROP_LEAD));
    assign hold_end  = (sec_tick == rps_pkg::CNT_W'(cfg.hold_seconds));

    assign q_signed = rps_pkg::ACC_W'(div_q);
    assign pct_acc  = (neg_reg ? -q_signed : q_signed) + rps_pkg::ACC_W'(ofs_reg);

    always_comb
    begin
        st_next        = st_reg;
        phase_next     = phase_reg;
        setpoint_next  = setpoint_reg;
        sec_cnt_next   = sec_cnt_reg;
        idle_cnt_next  = idle_cnt_reg;
        percent_next   = percent_reg;
        stop_next      = stop_reg;
        minute_next    = minute_reg;
        toggle_next    = toggle_reg;
        div_start      = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_phase_next = out_phase_reg;
        out_pct_next   = out_pct_reg;
        out_sp_next    = out_sp_reg;
        out_stop_next  = out_stop_reg;
        out_min_next   = out_min_reg;
        out_tog_next   = out_tog_reg;

        case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    stop_next   = 1'b0;
                    minute_next = 1'b0;
                    toggle_next = 1'b0;
                    st_next     = ST_DONE;
                    if (action)
                    begin
                        phase_next    = rps_pkg::PH_PREHEAT;
                        setpoint_next = start_setpoint;
                        percent_next  = '0;
                    end
                    else
                    begin
                        if (idle_tick)
                        begin
                            idle_cnt_next = idle_inc;
                            toggle_next   = (idle_inc == cfg.display_sleep_seconds)
                                         && !display_asleep;
                        end
                        else
                        begin
                            idle_cnt_next = '0;
                        end
                        sec_cnt_next = sec_tick;
                        minute_next  = minute_hit;

                        case (phase_reg)
                            rps_pkg::PH_PREHEAT:
                            begin
                                div_start = 1'b1;
                                st_next   = ST_DIV;
                                if ({1'b0, setpoint_reg} < pre_sp)
                                begin
                                    setpoint_next = (sp_ramp > pre_sp)
                                                  ? pre_sp[rps_pkg::TEMP_BITS-1:0]
                                                  : sp_ramp[rps_pkg::TEMP_BITS-1:0];
                                end
                                else if (meas_temp >= setpoint_reg)
                                begin
                                    phase_next   = rps_pkg::PH_SOAK;
                                    sec_cnt_next = '0;
                                end
                            end
                            rps_pkg::PH_SOAK:
                            begin
                                div_start = 1'b1;
                                st_next   = ST_DIV;
                                if (sec_tick == rps_pkg::CNT_W'(cfg.soak_seconds))
                                begin
                                    phase_next    = rps_pkg::PH_PEAK;
                                    setpoint_next = rps_pkg::TEMP_BITS'(cfg.peak_temp);
                                end
                            end
                            rps_pkg::PH_PEAK:
                            begin
                                div_start = 1'b1;
                                st_next   = ST_DIV;
                                if (meas_temp > rps_pkg::PEAK_EXIT_TEMP)
                                begin
                                    phase_next   = rps_pkg::PH_HOLD;
                                    sec_cnt_next = '0;
                                end
                            end
                            rps_pkg::PH_HOLD:
                            begin
                                if (hold_drop)
                                begin
                                    setpoint_next = '0;
                                    div_start     = 1'b1;
                                    st_next       = ST_DIV;
                                end
                                else if (hold_end)
                                begin
                                    // profile done: percent is fixed, no divide
                                    phase_next   = rps_pkg::PH_IDLE;
                                    percent_next = rps_pkg::PCT_DONE;
                                    stop_next    = 1'b1;
                                end
                                else
                                begin
                                    div_start = 1'b1;
                                    st_next   = ST_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    percent_next = rps_pkg::sat_pct(pct_acc);
                    st_next      = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_phase_next = phase_reg;
                    out_pct_next   = percent_reg;
                    out_sp_next    = setpoint_reg;
                    out_stop_next  = stop_reg;
                    out_min_next   = minute_reg;
                    out_tog_next   = toggle_reg;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            phase_reg     <= rps_pkg::PH_IDLE;
            setpoint_reg  <= '0;
            sec_cnt_reg   <= '0;
            idle_cnt_reg  <= '0;
            percent_reg   <= '0;
            stop_reg      <= 1'b0;
            minute_reg    <= 1'b0;
            toggle_reg    <= 1'b0;
            neg_reg       <= 1'b0;
            ofs_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_phase_reg <= rps_pkg::PH_IDLE;
            out_pct_reg   <= '0;
            out_sp_reg    <= '0;
            out_stop_reg  <= 1'b0;
            out_min_reg   <= 1'b0;
            out_tog_reg   <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            setpoint_reg  <= setpoint_next;
            sec_cnt_reg   <= sec_cnt_next;
            idle_cnt_reg  <= idle_cnt_next;
            percent_reg   <= percent_next;
            stop_reg      <= stop_next;
            minute_reg    <= minute_next;
            toggle_reg    <= toggle_next;
            if (div_start)
            begin
                neg_reg <= neg_next;
                ofs_reg <= ofs_next;
            end
            out_valid_reg <= out_valid_next;
            out_phase_reg <= out_phase_next;
            out_pct_reg   <= out_pct_next;
            out_sp_reg    <= out_sp_next;
            out_stop_reg  <= out_stop_next;
            out_min_reg   <= out_min_next;
            out_tog_reg   <= out_tog_next;
        end
    end

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> st_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> st_reg != ST_IDLE)
        else $error("accepted beat left no work pending");

    a_stop_means_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && heater_stop) |-> (phase == rps_pkg::PH_IDLE && percent == rps_pkg::PCT_DONE))
        else $error("stop pulse without profile end state");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(st_reg == ST_DONE))
        else $error("result beat raised outside the done state");

endmodule

`default_nettype wire

@@ rtl/rps_apb_regs.sv @@
// ----------------------------------------------------------------------------
// rps_apb_regs
// APB-style configuration registers of the profile sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_apb_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rps_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output rps_pkg::cfg_t                     cfg
);

    rps_pkg::cfg_t     cfg_reg;
    rps_pkg::cfg_t     cfg_next;
    rps_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = rps_pkg::reg_idx_t'(paddr[rps_pkg::PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                rps_pkg::REG_PREHEAT_TEMP:  cfg_next.preheat_temp          = pwdata[7:0];
                rps_pkg::REG_SOAK_SECONDS:  cfg_next.soak_seconds          = pwdata[7:0];
                rps_pkg::REG_PEAK_TEMP:     cfg_next.peak_temp             = pwdata[8:0];
                rps_pkg::REG_HOLD_SECONDS:  cfg_next.hold_seconds          = pwdata[7:0];
                rps_pkg::REG_DISPLAY_SLEEP: cfg_next.display_sleep_seconds = pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            rps_pkg::REG_PREHEAT_TEMP:  prdata = 32'(cfg_reg.preheat_temp);
            rps_pkg::REG_SOAK_SECONDS:  prdata = 32'(cfg_reg.soak_seconds);
            rps_pkg::REG_PEAK_TEMP:     prdata = 32'(cfg_reg.peak_temp);
            rps_pkg::REG_HOLD_SECONDS:  prdata = 32'(cfg_reg.hold_seconds);
            rps_pkg::REG_DISPLAY_SLEEP: prdata = 32'(cfg_reg.display_sleep_seconds);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preheat_temp          <= 8'd150;
            cfg_reg.soak_seconds          <= 8'd90;
            cfg_reg.peak_temp             <= 9'd230;
            cfg_reg.hold_seconds          <= 8'd60;
            cfg_reg.display_sleep_seconds <= 8'd60;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rps_serial_div.sv @@
// ----------------------------------------------------------------------------
// rps_serial_div
// Bit-serial restoring divider: one quotient bit per clock, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_serial_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [rps_pkg::NUM_W-1:0]   dividend,
    input  wire logic [rps_pkg::DVS_W-1:0]   divisor,
    output logic                             done,
    output logic      [rps_pkg::NUM_W-1:0]   quotient
);

    logic                          busy_reg,  busy_next;
    logic                          done_reg,  done_next;
    logic [rps_pkg::STEP_W-1:0]    step_reg,  step_next;
    logic [rps_pkg::NUM_W-1:0]     dvd_reg,   dvd_next;
    logic [rps_pkg::DVS_W-1:0]     rem_reg,   rem_next;
    logic [rps_pkg::DVS_W-1:0]     dvs_reg,   dvs_next;
    logic [rps_pkg::DVS_W:0]       shifted;
    logic [rps_pkg::DVS_W:0]       diff;
    logic                          fits;

    // partial remainder shifted by one dividend bit; dividend bits leave
    // at the top while quotient bits enter at the bottom
    assign shifted = {rem_reg, dvd_reg[rps_pkg::NUM_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[rps_pkg::NUM_W-2:0], fits};
            rem_next = fits ? diff[rps_pkg::DVS_W-1:0] : shifted[rps_pkg::DVS_W-1:0];
            if (step_reg == rps_pkg::STEP_W'(rps_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            dvd_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            dvd_reg  <= dvd_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
        end
    end

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench of reflow_profile_sequencer_unit. A cycle-free profile predictor
// tracks phase, setpoint, counters and progress percent for every accepted
// tick or start beat. A monitor pops one predicted status per result beat and
// checks it field by field. The tests cover reset defaults, register access, a directed
// profile through all phases, display wake, random profiles under random
// idling, a long result stall and a final stream without idling.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_TICK      = 1'b0;
    localparam logic ACT_START     = 1'b1;
    localparam int   PCT_SCALE     = 10;
    localparam int   DIV_DEN       = 25;
    localparam int   PCT_LO        = -1024;
    localparam int   PCT_HI        = 1023;
    localparam int   TEMP_MAX      = (1 << rps_pkg::TEMP_BITS) - 1;
    localparam int   SEC_WRAP      = 1 << rps_pkg::CNT_W;
    localparam int   IDLE_WRAP     = 1 << rps_pkg::IDLE_W;
    localparam int   STALL_CYCLES  = 300;
    localparam int   WATCHDOG_MAX  = 4000;
    localparam int   FLUSH_CYCLES  = 40;
    localparam int   RANDOM_BEATS  = 1650;

    localparam rps_pkg::cfg_t CFG_DEFAULT = '{8'd150, 8'd90, 9'd230, 8'd60, 8'd60};
    localparam rps_pkg::cfg_t CFG_LOW     = '{8'd39, 8'd1, 9'd0, 8'd11, 8'd1};
    localparam rps_pkg::cfg_t CFG_HIGH    = '{8'd216, 8'd255, 9'd300, 8'd255, 8'd255};

    typedef struct {
        logic                          action;
        logic [rps_pkg::TEMP_BITS-1:0] meas_temp;
        logic                          heater_on;
        logic                          temp_reached;
        logic                          display_asleep;
        logic [rps_pkg::TEMP_BITS-1:0] start_setpoint;
    } tick_beat_t;

    typedef struct {
        logic [2:0]                       phase;
        logic signed [rps_pkg::PCT_W-1:0] percent;
        logic [rps_pkg::TEMP_BITS-1:0]    setpoint;
        logic                             heater_stop;
        logic                             minute_pulse;
        logic                             display_toggle_request;
    } profile_status_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [rps_pkg::PADDR_W-1:0]      paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic                             action = 1'b0;
    logic [rps_pkg::TEMP_BITS-1:0]    meas_temp = '0;
    logic                             heater_on = 1'b0;
    logic                             temp_reached = 1'b0;
    logic                             display_asleep = 1'b0;
    logic [rps_pkg::TEMP_BITS-1:0]    start_setpoint = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [2:0]                       phase;
    logic signed [rps_pkg::PCT_W-1:0] percent;
    logic [rps_pkg::TEMP_BITS-1:0]    setpoint;
    logic                             heater_stop;
    logic                             minute_pulse;
    logic                             display_toggle_request;

    // predictor state and register shadow
    rps_pkg::cfg_t   cfg_shadow = CFG_DEFAULT;
    rps_pkg::phase_t profile_phase = rps_pkg::PH_IDLE;
    int              setpoint_model = 0;
    int              second_count = 0;
    int              idle_count = 0;
    int              percent_model = 0;

    profile_status_t pending_status[$];
    profile_status_t want_status;
    int              mismatch_count = 0;
    int              ticks_issued = 0;
    int              quiet_cycles = 0;
    bit              feed_gaps = 1'b0;
    bit              drain_stalls = 1'b0;
    bit              long_stall_req = 1'b0;
    int              stall_left = 0;
    int              burst_left = 0;

    reflow_profile_sequencer_unit u_top (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready),
        .in_valid               (in_valid),
        .in_ready               (in_ready),
        .action                 (action),
        .meas_temp              (meas_temp),
        .heater_on              (heater_on),
        .temp_reached           (temp_reached),
        .display_asleep         (display_asleep),
        .start_setpoint         (start_setpoint),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .phase                  (phase),
        .percent                (percent),
        .setpoint               (setpoint),
        .heater_stop            (heater_stop),
        .minute_pulse           (minute_pulse),
        .display_toggle_request (display_toggle_request)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // profile predictor
    // ------------------------------------------------------------------
    function automatic int clamp_percent(input int v);
        if (v < PCT_LO)
        begin
            return PCT_LO;
        end
        if (v > PCT_HI)
        begin
            return PCT_HI;
        end
        return v;
    endfunction

    function automatic int span_divisor(input int span);
        int d;
        d = span * PCT_SCALE / DIV_DEN;
        return (d < 1) ? 1 : d;
    endfunction

    function automatic void predict_status(input tick_beat_t b);
        profile_status_t r;
        int now_i;
        int pre;
        int cnt;
        int amb;
        r = '{default: '0};
        now_i = int'(b.meas_temp);
        pre = int'(cfg_shadow.preheat_temp);
        amb = int'(rps_pkg::AMBIENT_SPAN);
        if (b.action == ACT_START)
        begin
            profile_phase = rps_pkg::PH_PREHEAT;
            setpoint_model = int'(b.start_setpoint);
            percent_model = 0;
        end
        else
        begin
            if (b.meas_temp == rps_pkg::AMBIENT_TEMP && !b.heater_on)
            begin
                idle_count = (idle_count + 1) % IDLE_WRAP;
                if (idle_count == int'(cfg_shadow.display_sleep_seconds)
                    && !b.display_asleep)
                begin
                    r.display_toggle_request = 1'b1;
                end
            end
            else
            begin
                idle_count = 0;
            end

            second_count = (second_count + 1) % SEC_WRAP;
            if (b.temp_reached && second_count == int'(rps_pkg::MINUTE_SECONDS))
            begin
                second_count = 0;
                r.minute_pulse = 1'b1;
            end

            cnt = second_count;
            case (profile_phase)
                rps_pkg::PH_PREHEAT:
                begin
                    percent_model = clamp_percent((now_i - amb) * PCT_SCALE
                                                  / span_divisor(pre - amb));
                    if (setpoint_model < pre)
                    begin
                        setpoint_model = setpoint_model + int'(rps_pkg::RAMP_STEP);
                        if (setpoint_model > pre)
                        begin
                            setpoint_model = pre;
                        end
                    end
                    else if (now_i >= setpoint_model)
                    begin
                        profile_phase = rps_pkg::PH_SOAK;
                        second_count = 0;
                    end
                end
                rps_pkg::PH_SOAK:
                begin
                    percent_model = clamp_percent(int'(rps_pkg::PCT_OFS_SOAK)
                                    + cnt * PCT_SCALE
                                    / span_divisor(int'(cfg_shadow.soak_seconds)));
                    if (cnt == int'(cfg_shadow.soak_seconds))
                    begin
                        profile_phase = rps_pkg::PH_PEAK;
                        setpoint_model = int'(cfg_shadow.peak_temp);
                    end
                end
                rps_pkg::PH_PEAK:
                begin
                    percent_model = clamp_percent(int'(rps_pkg::PCT_OFS_PEAK)
                                    + (now_i - pre) * PCT_SCALE
                                    / span_divisor(int'(rps_pkg::PEAK_SPAN_TOP) - pre));
                    if (now_i > int'(rps_pkg::PEAK_EXIT_TEMP))
                    begin
                        profile_phase = rps_pkg::PH_HOLD;
                        second_count = 0;
                    end
                end
                rps_pkg::PH_HOLD:
                begin
                    percent_model = clamp_percent(int'(rps_pkg::PCT_OFS_HOLD)
                                    + cnt * PCT_SCALE
                                    / span_divisor(int'(cfg_shadow.hold_seconds)));
                    // early drop wins over the end test on the same tick
                    if (cnt == int'(cfg_shadow.hold_seconds)
                               - int'(rps_pkg::HOLD_DROP_LEAD))
                    begin
                        setpoint_model = 0;
                    end
                    else if (cnt == int'(cfg_shadow.hold_seconds))
                    begin
                        profile_phase = rps_pkg::PH_IDLE;
                        percent_model = int'(rps_pkg::PCT_DONE);
                        r.heater_stop = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.phase = profile_phase;
        r.percent = rps_pkg::PCT_W'(percent_model);
        r.setpoint = rps_pkg::TEMP_BITS'(setpoint_model);
        pending_status.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
            begin
                report_mismatch("result beat with no status pending");
            end
            else
            begin
                want_status = pending_status.pop_front();
                if (phase !== want_status.phase)
                    report_mismatch($sformatf("phase %0d, want %0d", phase, want_status.phase));
                if (percent !== want_status.percent)
                    report_mismatch($sformatf("percent %0d, want %0d",
                                              percent, want_status.percent));
                if (setpoint !== want_status.setpoint)
                    report_mismatch($sformatf("setpoint %0d, want %0d",
                                              setpoint, want_status.setpoint));
                if (heater_stop !== want_status.heater_stop)
                    report_mismatch($sformatf("heater_stop %b, want %b",
                                              heater_stop, want_status.heater_stop));
                if (minute_pulse !== want_status.minute_pulse)
                    report_mismatch($sformatf("minute_pulse %b, want %b",
                                              minute_pulse, want_status.minute_pulse));
                if (display_toggle_request !== want_status.display_toggle_request)
                    report_mismatch($sformatf("display_toggle_request %b, want %b",
                                              display_toggle_request,
                                              want_status.display_toggle_request));
            end
        end
    end

    // result side: random stall bursts, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (long_stall_req)
        begin
            long_stall_req = 1'b0;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if (burst_left > 0)
        begin
            out_ready <= 1'b0;
            burst_left--;
        end
        else if (drain_stalls && $urandom_range(3, 0) == 0)
        begin
            out_ready <= 1'b0;
            burst_left = $urandom_range(6, 0);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_MAX)
                begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // configuration bus
    // ------------------------------------------------------------------
    task automatic bus_access(input rps_pkg::reg_idx_t idx, input logic wr,
                              input logic [31:0] value, output logic [31:0] rdata);
        // a transfer that ended this step still has psel pending low
        if (psel)
        begin
            @(posedge clk);
        end
        psel <= 1'b1;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cfg_write(input rps_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] unused;
        bus_access(idx, 1'b1, value, unused);
        case (idx)
            rps_pkg::REG_PREHEAT_TEMP:  cfg_shadow.preheat_temp = value[7:0];
            rps_pkg::REG_SOAK_SECONDS:  cfg_shadow.soak_seconds = value[7:0];
            rps_pkg::REG_PEAK_TEMP:     cfg_shadow.peak_temp = value[8:0];
            rps_pkg::REG_HOLD_SECONDS:  cfg_shadow.hold_seconds = value[7:0];
            rps_pkg::REG_DISPLAY_SLEEP: cfg_shadow.display_sleep_seconds = value[7:0];
            default:                    ;
        endcase
    endtask

    task automatic cfg_readback(input rps_pkg::reg_idx_t idx, input logic [31:0] value);
        logic [31:0] got;
        bus_access(idx, 1'b0, '0, got);
        if (got !== value)
            report_mismatch($sformatf("register %s reads %0d, want %0d", idx.name(), got, value));
    endtask

    task automatic program_settings(input rps_pkg::cfg_t c);
        cfg_write(rps_pkg::REG_PREHEAT_TEMP, 32'(c.preheat_temp));
        cfg_write(rps_pkg::REG_SOAK_SECONDS, 32'(c.soak_seconds));
        cfg_write(rps_pkg::REG_PEAK_TEMP, 32'(c.peak_temp));
        cfg_write(rps_pkg::REG_HOLD_SECONDS, 32'(c.hold_seconds));
        cfg_write(rps_pkg::REG_DISPLAY_SLEEP, 32'(c.display_sleep_seconds));
    endtask

    task automatic check_settings(input rps_pkg::cfg_t c);
        cfg_readback(rps_pkg::REG_PREHEAT_TEMP, 32'(c.preheat_temp));
        cfg_readback(rps_pkg::REG_SOAK_SECONDS, 32'(c.soak_seconds));
        cfg_readback(rps_pkg::REG_PEAK_TEMP, 32'(c.peak_temp));
        cfg_readback(rps_pkg::REG_HOLD_SECONDS, 32'(c.hold_seconds));
        cfg_readback(rps_pkg::REG_DISPLAY_SLEEP, 32'(c.display_sleep_seconds));
    endtask

    function automatic int pick_setting(input int lo, input int hi, input int usual_hi);
        case ($urandom_range(7, 0))
            0:       return lo;
            1:       return hi;
            2:       return $urandom_range(hi, lo);
            default: return $urandom_range(usual_hi, lo);
        endcase
    endfunction

    function automatic rps_pkg::cfg_t random_settings();
        rps_pkg::cfg_t c;
        c.preheat_temp = 8'(pick_setting(39, 216, 216));
        c.soak_seconds = 8'(pick_setting(1, 255, 12));
        c.peak_temp = 9'(pick_setting(0, 300, 300));
        c.hold_seconds = 8'(pick_setting(11, 255, 24));
        c.display_sleep_seconds = 8'(pick_setting(1, 255, 6));
        return c;
    endfunction

    // ------------------------------------------------------------------
    // input beats
    // ------------------------------------------------------------------
    task automatic send_beat(input tick_beat_t b);
        if (feed_gaps && $urandom_range(2, 0) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= b.action;
        meas_temp <= b.meas_temp;
        heater_on <= b.heater_on;
        temp_reached <= b.temp_reached;
        display_asleep <= b.display_asleep;
        start_setpoint <= b.start_setpoint;
        do
            @(posedge clk);
        while (!in_ready);
        predict_status(b);
        ticks_issued++;
    endtask

    task automatic tick(input logic [rps_pkg::TEMP_BITS-1:0] temp, input logic heat,
                        input logic reached, input logic asleep);
        tick_beat_t b;
        b.action = ACT_TICK;
        b.meas_temp = temp;
        b.heater_on = heat;
        b.temp_reached = reached;
        b.display_asleep = asleep;
        b.start_setpoint = rps_pkg::TEMP_BITS'($urandom());
        send_beat(b);
    endtask

    task automatic send_start(input logic [rps_pkg::TEMP_BITS-1:0] sp);
        tick_beat_t b;
        b.action = ACT_START;
        b.meas_temp = rps_pkg::TEMP_BITS'($urandom());
        b.heater_on = 1'($urandom());
        b.temp_reached = 1'($urandom());
        b.display_asleep = 1'($urandom());
        b.start_setpoint = sp;
        send_beat(b);
    endtask

    // plate temperature that follows the predicted profile, with some noise
    function automatic logic [rps_pkg::TEMP_BITS-1:0] plate_temp();
        int v;
        if ($urandom_range(15, 0) == 0)
        begin
            return rps_pkg::TEMP_BITS'($urandom());
        end
        case (profile_phase)
            rps_pkg::PH_PREHEAT, rps_pkg::PH_SOAK:
            begin
                v = setpoint_model + int'($urandom_range(6, 0)) - 2;
                v = (v < 0) ? 0 : ((v > TEMP_MAX) ? TEMP_MAX : v);
            end
            rps_pkg::PH_PEAK: v = $urandom_range(260, 150);
            rps_pkg::PH_HOLD: v = $urandom_range(260, 200);
            default: v = $urandom_range(1, 0) ? int'(rps_pkg::AMBIENT_TEMP)
                                              : int'($urandom_range(TEMP_MAX, 0));
        endcase
        return rps_pkg::TEMP_BITS'(v);
    endfunction

    task automatic send_random_tick();
        logic heat;
        heat = (profile_phase == rps_pkg::PH_IDLE) ? ($urandom_range(3, 0) == 0)
                                                   : 1'($urandom());
        tick(plate_temp(), heat, $urandom_range(7, 0) == 0, 1'($urandom()));
    endtask

    function automatic logic [rps_pkg::TEMP_BITS-1:0] random_start_setpoint();
        int v;
        if ($urandom_range(9, 0) < 3)
        begin
            return rps_pkg::TEMP_BITS'($urandom());
        end
        v = int'(cfg_shadow.preheat_temp) - int'($urandom_range(60, 0));
        return rps_pkg::TEMP_BITS'((v < 0) ? 0 : v);
    endfunction

    task automatic run_profile(input int max_ticks);
        int n;
        send_start(random_start_setpoint());
        n = 0;
        while (profile_phase != rps_pkg::PH_IDLE && n < max_ticks)
        begin
            if ($urandom_range(79, 0) == 0)
            begin
                send_start(random_start_setpoint());
            end
            else
            begin
                send_random_tick();
            end
            n++;
        end
        repeat ($urandom_range(6, 0)) send_random_tick();
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_status.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        check_settings(CFG_DEFAULT);
        tick(9'd100, 1'b0, 1'b0, 1'b0);
        drain_results();
    endtask

    task automatic test_register_access();
        program_settings(CFG_LOW);
        check_settings(CFG_LOW);
        program_settings(CFG_HIGH);
        check_settings(CFG_HIGH);
    endtask

    task automatic test_directed_profile();
        program_settings('{8'd216, 8'd1, 9'd300, 8'd11, 8'd1});
        tick(rps_pkg::AMBIENT_TEMP, 1'b0, 1'b0, 1'b0);   // wake request after one idle second
        tick(rps_pkg::AMBIENT_TEMP, 1'b1, 1'b1, 1'b0);   // heater on clears the idle count
        send_start(9'd511);
        send_start(9'd0);                                // restart while running
        tick(9'd511, 1'b1, 1'b0, 1'b1);                  // ramp by 3
        send_start(9'd216);
        tick(9'd216, 1'b0, 1'b1, 1'b0);                  // at target: into soak
        tick(9'd100, 1'b1, 1'b0, 1'b1);                  // one-second soak ends
        tick(9'd0, 1'b0, 1'b1, 1'b1);                    // percent floor
        tick(rps_pkg::PEAK_EXIT_TEMP, 1'b1, 1'b0, 1'b0); // not above exit temp
        tick(9'd511, 1'b0, 1'b0, 1'b1);                  // into hold, percent ceiling
        // drop at second 1, end at second 11
        repeat (11) tick(rps_pkg::TEMP_BITS'($urandom_range(260, 200)), 1'($urandom()),
                         1'($urandom()), 1'($urandom()));
        tick(rps_pkg::AMBIENT_TEMP, 1'b1, 1'b0, 1'b0);   // idle keeps the final percent
        drain_results();
    endtask

    task automatic test_display_wake();
        rps_pkg::cfg_t c;
        feed_gaps = 1'b1;
        drain_stalls = 1'b1;
        c = CFG_DEFAULT;
        c.display_sleep_seconds = 8'd255;
        program_settings(c);
        // long enough to match at 255 and wrap the idle count
        repeat (260) tick(rps_pkg::AMBIENT_TEMP, 1'b0, 1'($urandom()),
                          $urandom_range(3, 0) == 0);
        drain_results();
        c.display_sleep_seconds = 8'(pick_setting(1, 255, 6));
        program_settings(c);
        repeat (90)
        begin
            if ($urandom_range(4, 0) != 0)
                tick(rps_pkg::AMBIENT_TEMP, $urandom_range(7, 0) == 0, 1'($urandom()),
                     $urandom_range(3, 0) == 0);
            else
                tick(rps_pkg::TEMP_BITS'($urandom()), 1'($urandom()), 1'($urandom()),
                     1'($urandom()));
        end
        drain_results();
    endtask

    task automatic test_random_profiles();
        while (ticks_issued < RANDOM_BEATS)
        begin
            program_settings(random_settings());
            feed_gaps = ($urandom_range(3, 0) != 0);
            drain_stalls = ($urandom_range(3, 0) != 0);
            run_profile(600);
            drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        program_settings(random_settings());
        feed_gaps = 1'b0;
        drain_stalls = 1'b0;
        long_stall_req = 1'b1;
        run_profile(50);
        drain_results();
    endtask

    task automatic test_steady_stream();
        program_settings(random_settings());
        feed_gaps = 1'b0;
        drain_stalls = 1'b0;
        run_profile(150);
        drain_results();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_register_access();
        test_directed_profile();
        test_display_wake();
        test_random_profiles();
        test_output_backpressure();
        test_steady_stream();
        repeat (FLUSH_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
